FILE: rtl/daoa_pkg.sv
// Shared types, register codes and reset constants for the DAC amplitude/offset aligner.
`default_nettype none

package daoa_pkg;

  localparam int DEF_VOLT_BITS      = 14;
  localparam int DEF_GAIN_FRAC_BITS = 16;

  localparam int OMAX_W     = 12;
  localparam int MINVPP_W   = 12;
  localparam int GAIN_W     = 18;
  localparam int FS_W       = 16;
  localparam int CHAN_W     = 3;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int DAC_IDX_W  = 4;

  localparam int RESET_VPP = 500;

  localparam logic [OMAX_W-1:0]   RST_OUTPUT_MAX = OMAX_W'(500);
  localparam logic [MINVPP_W-1:0] RST_MIN_VPP    = MINVPP_W'(10);
  localparam logic [GAIN_W-1:0]   RST_VPP_GAIN   = GAIN_W'(67043);
  localparam logic [GAIN_W-1:0]   RST_VO_GAIN    = GAIN_W'(67043);
  localparam logic [FS_W-1:0]     RST_FULL_SCALE = FS_W'(1023);
  localparam logic [CHAN_W-1:0]   RST_CHANNEL    = CHAN_W'(0);

  typedef enum logic [KIND_W-1:0] {
    KIND_VPP    = 2'd0,
    KIND_OFFSET = 2'd1,
    KIND_VMIN   = 2'd2,
    KIND_VMAX   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTPUT_MAX = 3'd0,
    REG_MIN_VPP    = 3'd1,
    REG_VPP_GAIN   = 3'd2,
    REG_VO_GAIN    = 3'd3,
    REG_FULL_SCALE = 3'd4,
    REG_CHANNEL    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [OMAX_W-1:0]   output_max;
    logic [MINVPP_W-1:0] min_vpp;
    logic [GAIN_W-1:0]   vpp_gain;
    logic [GAIN_W-1:0]   vo_gain;
    logic [FS_W-1:0]     dac_full_scale;
    logic [CHAN_W-1:0]   channel;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/daoa_in_if.sv
// Input channel: one write request per item.
`default_nettype none

interface daoa_in_if #(
  parameter int VOLT_BITS = daoa_pkg::DEF_VOLT_BITS
);
  logic                          valid;
  logic                          ready;
  logic [daoa_pkg::KIND_W-1:0]   kind;
  logic signed [VOLT_BITS-1:0]   write_value;
  logic                          force_update;

  modport source (output valid, kind, write_value, force_update, input ready);
  modport sink   (input valid, kind, write_value, force_update, output ready);
endinterface

`default_nettype wire

FILE: rtl/daoa_out_if.sv
// Output channel: aligned voltages and DAC words per item.
`default_nettype none

interface daoa_out_if #(
  parameter int VOLT_BITS = daoa_pkg::DEF_VOLT_BITS
);
  logic                             valid;
  logic                             ready;
  logic [VOLT_BITS-2:0]             out_vpp;
  logic signed [VOLT_BITS-2:0]      out_offset;
  logic signed [VOLT_BITS-1:0]      out_vmin;
  logic signed [VOLT_BITS-1:0]      out_vmax;
  logic [daoa_pkg::FS_W-1:0]        amp_word;
  logic [daoa_pkg::FS_W-1:0]        ofs_word;
  logic [daoa_pkg::DAC_IDX_W-1:0]   amp_dac_index;
  logic                             hw_update;

  modport source (output valid, out_vpp, out_offset, out_vmin, out_vmax, amp_word,
                  ofs_word, amp_dac_index, hw_update, input ready);
  modport sink   (input valid, out_vpp, out_offset, out_vmin, out_vmax, amp_word,
                  ofs_word, amp_dac_index, hw_update, output ready);
endinterface

`default_nettype wire

FILE: rtl/daoa_cfg_regs.sv
// Configuration register file with write-only access.
`default_nettype none

module daoa_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [daoa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [daoa_pkg::CFG_DATA_W-1:0]     cfg_data,
  output daoa_pkg::cfg_t                           cfg
);

  daoa_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.output_max     <= daoa_pkg::RST_OUTPUT_MAX;
      regs.min_vpp        <= daoa_pkg::RST_MIN_VPP;
      regs.vpp_gain       <= daoa_pkg::RST_VPP_GAIN;
      regs.vo_gain        <= daoa_pkg::RST_VO_GAIN;
      regs.dac_full_scale <= daoa_pkg::RST_FULL_SCALE;
      regs.channel        <= daoa_pkg::RST_CHANNEL;
    end else if (cfg_write) begin
      unique case (daoa_pkg::cfg_reg_t'(cfg_index))
        daoa_pkg::REG_OUTPUT_MAX: regs.output_max <= cfg_data[daoa_pkg::OMAX_W-1:0];
        daoa_pkg::REG_MIN_VPP:    regs.min_vpp    <= cfg_data[daoa_pkg::MINVPP_W-1:0];
        daoa_pkg::REG_VPP_GAIN:   regs.vpp_gain   <= cfg_data[daoa_pkg::GAIN_W-1:0];
        daoa_pkg::REG_VO_GAIN:    regs.vo_gain    <= cfg_data[daoa_pkg::GAIN_W-1:0];
        daoa_pkg::REG_FULL_SCALE: regs.dac_full_scale <= cfg_data[daoa_pkg::FS_W-1:0];
        daoa_pkg::REG_CHANNEL:    regs.channel    <= cfg_data[daoa_pkg::CHAN_W-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

FILE: rtl/daoa_align.sv
// Realigns vpp, offset, vmin and vmax after one written quantity.
`default_nettype none

module daoa_align #(
  parameter int VOLT_BITS = daoa_pkg::DEF_VOLT_BITS
) (
  input  wire logic [daoa_pkg::KIND_W-1:0]     kind,
  input  wire logic signed [VOLT_BITS-1:0]     write_value,
  input  wire logic                            force_update,
  input  wire logic [VOLT_BITS-2:0]            held_vpp,
  input  wire logic signed [VOLT_BITS-2:0]     held_ofs,
  input  wire logic signed [VOLT_BITS-1:0]     held_vmin,
  input  wire logic signed [VOLT_BITS-1:0]     held_vmax,
  input  wire logic [daoa_pkg::OMAX_W-1:0]     output_max,
  input  wire logic [daoa_pkg::MINVPP_W-1:0]   min_vpp,
  output logic [VOLT_BITS-2:0]                 vpp_next,
  output logic signed [VOLT_BITS-2:0]          ofs_next,
  output logic signed [VOLT_BITS-1:0]          vmin_next,
  output logic signed [VOLT_BITS-1:0]          vmax_next,
  output logic                                 hw_update
);

  localparam int VW = VOLT_BITS;
  localparam int PW = VOLT_BITS - 1;
  localparam int W  = VOLT_BITS + 2;

  localparam logic signed [W-1:0] VPP_HI = {3'b000, {(VW-1){1'b1}}};
  localparam logic signed [W-1:0] OFS_HI = {4'b0000, {(VW-2){1'b1}}};
  localparam logic signed [W-1:0] OFS_LO = {4'b1111, {(VW-2){1'b0}}};

  function automatic logic signed [W-1:0] clip(input logic signed [W-1:0] x,
                                               input logic signed [W-1:0] lo,
                                               input logic signed [W-1:0] hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  logic signed [W-1:0] v, hv, ho, hmin, hmax, omax, half_min;
  logic signed [W-1:0] lim, mag, vc, oc, vpp, ofs, vmin_w, vmax_w, span;
  logic signed [W-1:0] vmin_o, vmax_o;
  logic                chg;

  assign v        = {{2{write_value[VW-1]}}, write_value};
  assign hv       = {3'b000, held_vpp};
  assign ho       = {{3{held_ofs[PW-1]}}, held_ofs};
  assign hmin     = {{2{held_vmin[VW-1]}}, held_vmin};
  assign hmax     = {{2{held_vmax[VW-1]}}, held_vmax};
  assign omax     = {{(W-daoa_pkg::OMAX_W){1'b0}}, output_max};
  assign half_min = {{(W-daoa_pkg::MINVPP_W+1){1'b0}}, min_vpp[daoa_pkg::MINVPP_W-1:1]};

  always_comb begin
    chg    = 1'b0;
    vpp    = hv;
    ofs    = ho;
    lim    = '0;
    mag    = '0;
    vc     = '0;
    oc     = '0;
    vmin_w = hmin;
    vmax_w = hmax;
    span   = '0;
    unique case (daoa_pkg::kind_t'(kind))
      daoa_pkg::KIND_VPP: begin
        vc = clip(v, '0, VPP_HI);
        if (vc != hv) begin
          chg = 1'b1;
          vpp = vc;
          // pull the offset in so the peaks stay inside the output window
          lim = omax - (vc >>> 1);
          if (lim < 0) lim = '0;
          mag = (ho < 0) ? -ho : ho;
          if (mag > lim) ofs = (ho < 0) ? -lim : lim;
        end
      end
      daoa_pkg::KIND_OFFSET: begin
        oc = clip(v, OFS_LO, OFS_HI);
        if (oc != ho) begin
          chg = 1'b1;
          ofs = oc;
          mag = (oc < 0) ? -oc : oc;
          lim = (omax - mag) <<< 1;
          if (lim < 0) lim = '0;
          if (hv > lim) vpp = lim;
        end
      end
      daoa_pkg::KIND_VMIN: begin
        if (v != hmin) begin
          chg    = 1'b1;
          vmin_w = (v > ho - half_min) ? ho - half_min : v;
        end
      end
      daoa_pkg::KIND_VMAX: begin
        if (v != hmax) begin
          chg    = 1'b1;
          vmax_w = (v < ho + half_min) ? ho + half_min : v;
        end
      end
    endcase
    // rebuild span and center from the moved edge
    if (chg && (kind == daoa_pkg::KIND_VMIN || kind == daoa_pkg::KIND_VMAX)) begin
      span = clip(vmax_w - vmin_w, '0, VPP_HI);
      vpp  = span;
      ofs  = clip(vmin_w + (span >>> 1), OFS_LO, OFS_HI);
    end
    vmin_o = ofs - (vpp >>> 1);
    vmax_o = ofs + (vpp >>> 1);
  end

  assign vpp_next  = vpp[PW-1:0];
  assign ofs_next  = ofs[PW-1:0];
  assign vmin_next = vmin_o[VW-1:0];
  assign vmax_next = vmax_o[VW-1:0];
  assign hw_update = chg | force_update;

endmodule

`default_nettype wire

FILE: rtl/daoa_dac_word.sv
// Fixed-point gain conversion to a saturated DAC code: base - value*gain.
`default_nettype none

module daoa_dac_word #(
  parameter int VALUE_BITS     = daoa_pkg::DEF_VOLT_BITS,
  parameter int GAIN_FRAC_BITS = daoa_pkg::DEF_GAIN_FRAC_BITS
) (
  input  wire logic signed [VALUE_BITS-1:0]      value,
  input  wire logic [daoa_pkg::GAIN_W-1:0]       gain,
  input  wire logic [daoa_pkg::FS_W-1:0]         base,
  input  wire logic [daoa_pkg::FS_W-1:0]         full_scale,
  output logic [daoa_pkg::FS_W-1:0]              word
);

  localparam int PROD_W = VALUE_BITS + daoa_pkg::GAIN_W + 1;
  localparam int BASE_W = daoa_pkg::FS_W + GAIN_FRAC_BITS + 1;
  localparam int QW     = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 1;
  localparam int IW     = QW - 1 - GAIN_FRAC_BITS;

  logic signed [PROD_W-1:0] prod;
  logic signed [QW-1:0]     base_q;
  logic signed [QW-1:0]     q;
  logic [IW-1:0]            whole;
  logic [IW-1:0]            full_ext;

  assign prod     = value * $signed({1'b0, gain});
  assign base_q   = {{(QW-daoa_pkg::FS_W-GAIN_FRAC_BITS){1'b0}}, base, {GAIN_FRAC_BITS{1'b0}}};
  assign q        = base_q - QW'(prod);
  assign whole    = q[QW-2:GAIN_FRAC_BITS];
  assign full_ext = {{(IW-daoa_pkg::FS_W){1'b0}}, full_scale};

  always_comb begin
    if (q[QW-1]) begin
      word = '0;
    end else if (whole > full_ext) begin
      word = full_scale;
    end else begin
      word = whole[daoa_pkg::FS_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dac_amplitude_offset_aligner.sv
// An accepted item enters the input register, then the result register once that is free or read.
// Throughput: one item per cycle; a stalled result blocks input once the input register is full.
// Realignment, both gain multiplies and saturation run combinationally between the two registers.
// Reset: vpp 500, offset 0, vmin -250, vmax 250; configuration registers return to defaults.
// Reset empties both pipeline registers; no clearing pass is needed.
`default_nettype none

module dac_amplitude_offset_aligner #(
  parameter int VOLT_BITS      = daoa_pkg::DEF_VOLT_BITS,
  parameter int GAIN_FRAC_BITS = daoa_pkg::DEF_GAIN_FRAC_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  daoa_in_if.sink                               din,
  daoa_out_if.source                            dout,
  input  wire logic                             cfg_write,
  input  wire logic [daoa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [daoa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int VW = VOLT_BITS;
  localparam int PW = VOLT_BITS - 1;

  daoa_pkg::cfg_t cfg;

  // input register
  logic                           in_valid_q;
  logic [daoa_pkg::KIND_W-1:0]    in_kind_q;
  logic signed [VW-1:0]           in_value_q;
  logic                           in_force_q;

  // held state
  logic [PW-1:0]                  held_vpp;
  logic signed [PW-1:0]           held_ofs;
  logic signed [VW-1:0]           held_vmin;
  logic signed [VW-1:0]           held_vmax;

  // result register
  logic                           out_valid;
  logic [PW-1:0]                  vpp_q;
  logic signed [PW-1:0]           ofs_q;
  logic signed [VW-1:0]           vmin_q;
  logic signed [VW-1:0]           vmax_q;
  logic [daoa_pkg::FS_W-1:0]      amp_word_q;
  logic [daoa_pkg::FS_W-1:0]      ofs_word_q;
  logic [daoa_pkg::DAC_IDX_W-1:0] dac_idx_q;
  logic                           hw_q;

  logic [PW-1:0]                  al_vpp;
  logic signed [PW-1:0]           al_ofs;
  logic signed [VW-1:0]           al_vmin;
  logic signed [VW-1:0]           al_vmax;
  logic                           al_hw;
  logic [daoa_pkg::FS_W-1:0]      amp_word;
  logic [daoa_pkg::FS_W-1:0]      ofs_word;
  logic [daoa_pkg::FS_W-1:0]      ofs_base;

  logic adv;
  logic take;

  daoa_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  daoa_align #(
    .VOLT_BITS (VOLT_BITS)
  ) u_align (
    .kind         (in_kind_q),
    .write_value  (in_value_q),
    .force_update (in_force_q),
    .held_vpp     (held_vpp),
    .held_ofs     (held_ofs),
    .held_vmin    (held_vmin),
    .held_vmax    (held_vmax),
    .output_max   (cfg.output_max),
    .min_vpp      (cfg.min_vpp),
    .vpp_next     (al_vpp),
    .ofs_next     (al_ofs),
    .vmin_next    (al_vmin),
    .vmax_next    (al_vmax),
    .hw_update    (al_hw)
  );

  // offset midscale is full - full/2
  assign ofs_base = cfg.dac_full_scale - {1'b0, cfg.dac_full_scale[daoa_pkg::FS_W-1:1]};

  daoa_dac_word #(
    .VALUE_BITS     (VW),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_amp_word (
    .value      ($signed({1'b0, al_vpp})),
    .gain       (cfg.vpp_gain),
    .base       (cfg.dac_full_scale),
    .full_scale (cfg.dac_full_scale),
    .word       (amp_word)
  );

  daoa_dac_word #(
    .VALUE_BITS     (VW),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_ofs_word (
    .value      ($signed({al_ofs[PW-1], al_ofs})),
    .gain       (cfg.vo_gain),
    .base       (ofs_base),
    .full_scale (cfg.dac_full_scale),
    .word       (ofs_word)
  );

  assign adv       = !out_valid || dout.ready;
  assign din.ready = !in_valid_q || adv;
  assign take      = din.valid && din.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
      out_valid  <= 1'b0;
      held_vpp   <= PW'(daoa_pkg::RESET_VPP);
      held_ofs   <= '0;
      held_vmin  <= VW'(-(daoa_pkg::RESET_VPP / 2));
      held_vmax  <= VW'(daoa_pkg::RESET_VPP / 2);
    end else begin
      if (din.ready) begin
        in_valid_q <= din.valid;
      end
      if (adv) begin
        out_valid <= in_valid_q;
        if (in_valid_q) begin
          held_vpp  <= al_vpp;
          held_ofs  <= al_ofs;
          held_vmin <= al_vmin;
          held_vmax <= al_vmax;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_kind_q  <= din.kind;
      in_value_q <= din.write_value;
      in_force_q <= din.force_update;
    end
    if (adv && in_valid_q) begin
      vpp_q      <= al_vpp;
      ofs_q      <= al_ofs;
      vmin_q     <= al_vmin;
      vmax_q     <= al_vmax;
      amp_word_q <= amp_word;
      ofs_word_q <= ofs_word;
      dac_idx_q  <= {cfg.channel, 1'b0};
      hw_q       <= al_hw;
    end
  end

  assign dout.valid         = out_valid;
  assign dout.out_vpp       = vpp_q;
  assign dout.out_offset    = ofs_q;
  assign dout.out_vmin      = vmin_q;
  assign dout.out_vmax      = vmax_q;
  assign dout.amp_word      = amp_word_q;
  assign dout.ofs_word      = ofs_word_q;
  assign dout.amp_dac_index = dac_idx_q;
  assign dout.hw_update     = hw_q;

`ifndef SYNTHESIS
  a_held_coherent: assert property (@(posedge clk) disable iff (rst)
    held_vmin == ($signed({held_ofs[PW-1], held_ofs}) - $signed({2'b00, held_vpp[PW-1:1]}))
    && held_vmax == ($signed({held_ofs[PW-1], held_ofs}) + $signed({2'b00, held_vpp[PW-1:1]})))
    else $error("held vmin/vmax not centered on offset");

  a_force_raises_update: assert property (@(posedge clk) disable iff (rst)
    (adv && in_valid_q && in_force_q) |=> hw_q)
    else $error("forced item did not raise hw_update");

  a_ready_low_only_full: assert property (@(posedge clk) disable iff (rst)
    !din.ready |-> (in_valid_q && out_valid))
    else $error("input stalled with a free register");

  a_words_saturated: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> (dout.amp_word <= cfg.dac_full_scale && dout.ofs_word <= cfg.dac_full_scale))
    else $error("DAC word above full scale");
`endif

endmodule

`default_nettype wire

FILE: verif/aligner_checker.sv
// Checker for the DAC amplitude/offset aligner: predicts each result and compares it.
module aligner_checker import daoa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  daoa_in_if                    in_ch,
  daoa_out_if                   out_ch,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    checked,
  output int                    updates
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB  = DEF_VOLT_BITS;
  localparam int GFB = DEF_GAIN_FRAC_BITS;
  localparam longint VPP_TOP    = (longint'(1) << (VB - 1)) - 1;
  localparam longint OFS_TOP    = (longint'(1) << (VB - 2)) - 1;
  localparam longint OFS_BOTTOM = -(longint'(1) << (VB - 2));

  typedef struct packed {
    logic [VB-2:0]        vpp;
    logic signed [VB-2:0] offset;
    logic signed [VB-1:0] vmin;
    logic signed [VB-1:0] vmax;
    logic [FS_W-1:0]      amp_word;
    logic [FS_W-1:0]      ofs_word;
    logic [DAC_IDX_W-1:0] dac_index;
    logic                 hw_update;
  } aligned_t;

  cfg_t     regs;
  longint   held_vpp, held_offset, held_vmin, held_vmax;
  aligned_t due_results[$];
  aligned_t front;
  int       fails, seen, hw_seen;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Truncate a Q-format product to a code, saturated to 0..full scale.
  function automatic logic [FS_W-1:0] dac_code(longint q);
    longint fs;
    fs = longint'(regs.dac_full_scale);
    if (q < 0) return '0;
    q = q >>> GFB;
    return (q > fs) ? FS_W'(fs) : FS_W'(q);
  endfunction

  function automatic aligned_t align_write(kind_t k, logic signed [VB-1:0] wv, logic frc);
    longint   v, vpp, ofs, vmin, vmax, lim, mag, half_min, omax, fs;
    logic     hw, moved;
    aligned_t r;
    v        = wv;
    hw       = frc;
    moved    = 1'b0;
    vpp      = held_vpp;
    ofs      = held_offset;
    vmin     = held_vmin;
    vmax     = held_vmax;
    omax     = regs.output_max;
    half_min = regs.min_vpp >> 1;
    fs       = regs.dac_full_scale;
    case (k)
      KIND_VPP: begin
        v = clamp(v, 0, VPP_TOP);
        if (v != held_vpp) begin
          vpp = v;
          lim = omax - (vpp >>> 1);
          if (lim < 0) lim = 0;
          mag = (ofs < 0) ? -ofs : ofs;
          if (mag > lim) ofs = (ofs < 0) ? -lim : lim;
          hw = 1'b1;
        end
      end
      KIND_OFFSET: begin
        v = clamp(v, OFS_BOTTOM, OFS_TOP);
        if (v != held_offset) begin
          ofs = v;
          mag = (ofs < 0) ? -ofs : ofs;
          lim = (omax - mag) * 2;
          if (lim < 0) lim = 0;
          if (vpp > lim) vpp = lim;
          hw = 1'b1;
        end
      end
      KIND_VMIN: begin
        if (v != held_vmin) begin
          vmin = v;
          if (vmin > ofs - half_min) vmin = ofs - half_min;
          moved = 1'b1;
        end
      end
      default: begin
        if (v != held_vmax) begin
          vmax = v;
          if (vmax < ofs + half_min) vmax = ofs + half_min;
          moved = 1'b1;
        end
      end
    endcase
    if (moved) begin
      hw  = 1'b1;
      vpp = clamp(vmax - vmin, 0, VPP_TOP);
      ofs = clamp(vmin + (vpp >>> 1), OFS_BOTTOM, OFS_TOP);
    end
    held_vpp    = vpp;
    held_offset = ofs;
    held_vmin   = ofs - (vpp >>> 1);
    held_vmax   = ofs + (vpp >>> 1);
    r.vpp       = vpp[VB-2:0];
    r.offset    = ofs[VB-2:0];
    r.vmin      = held_vmin[VB-1:0];
    r.vmax      = held_vmax[VB-1:0];
    r.amp_word  = dac_code((fs <<< GFB) - vpp * longint'(regs.vpp_gain));
    r.ofs_word  = dac_code(((fs - fs / 2) <<< GFB) - ofs * longint'(regs.vo_gain));
    r.dac_index = DAC_IDX_W'({regs.channel, 1'b0});
    r.hw_update = hw;
    return r;
  endfunction

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs = '{output_max: RST_OUTPUT_MAX, min_vpp: RST_MIN_VPP, vpp_gain: RST_VPP_GAIN,
               vo_gain: RST_VO_GAIN, dac_full_scale: RST_FULL_SCALE, channel: RST_CHANNEL};
      held_vpp    = RESET_VPP;
      held_offset = 0;
      held_vmin   = -(RESET_VPP / 2);
      held_vmax   = RESET_VPP / 2;
      due_results.delete();
    end else begin
      // Compare first: a result can never belong to an item taken at this same edge.
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          fails++;
          $display("%0t ns: unexpected result, expected none, got vpp %0d offset %0d",
                   $time, out_ch.out_vpp, out_ch.out_offset);
        end else begin
          front = due_results.pop_front();
          check_field("out_vpp", front.vpp, out_ch.out_vpp);
          check_field("out_offset", front.offset, out_ch.out_offset);
          check_field("out_vmin", front.vmin, out_ch.out_vmin);
          check_field("out_vmax", front.vmax, out_ch.out_vmax);
          check_field("amp_word", front.amp_word, out_ch.amp_word);
          check_field("ofs_word", front.ofs_word, out_ch.ofs_word);
          check_field("amp_dac_index", front.dac_index, out_ch.amp_dac_index);
          check_field("hw_update", front.hw_update, out_ch.hw_update);
          seen++;
          if (front.hw_update) hw_seen++;
        end
      end
      if (in_ch.valid && in_ch.ready)
        due_results.push_back(align_write(kind_t'(in_ch.kind), in_ch.write_value,
                                          in_ch.force_update));
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_OUTPUT_MAX: regs.output_max     = cfg_data[OMAX_W-1:0];
          REG_MIN_VPP:    regs.min_vpp        = cfg_data[MINVPP_W-1:0];
          REG_VPP_GAIN:   regs.vpp_gain       = cfg_data[GAIN_W-1:0];
          REG_VO_GAIN:    regs.vo_gain        = cfg_data[GAIN_W-1:0];
          REG_FULL_SCALE: regs.dac_full_scale = cfg_data[FS_W-1:0];
          REG_CHANNEL:    regs.channel        = cfg_data[CHAN_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= fails;
    pending    <= due_results.size();
    checked    <= seen;
    updates    <= hw_seen;
  end
endmodule

FILE: verif/tb.sv
// Top of the aligner testbench: clock, reset, register setup, item stimulus and verdict.
module tb;
  import daoa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VOLT_W          = DEF_VOLT_BITS;
  localparam int ITEMS_PER_SETUP = 280;
  localparam int SETUP_COUNT     = 6;
  localparam int HOLD_CYCLES     = 80;
  localparam int CYCLE_LIMIT     = 400000;
  localparam cfg_t DEFAULT_SETUP = '{output_max: RST_OUTPUT_MAX, min_vpp: RST_MIN_VPP,
                                     vpp_gain: RST_VPP_GAIN, vo_gain: RST_VO_GAIN,
                                     dac_full_scale: RST_FULL_SCALE, channel: RST_CHANNEL};

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   fail_count, pending, checked, updates;
  int   items_sent, setups_done, cycles, hold_asked;
  bit   gaps_on;
  cfg_t setup;
  int   last_val[4];

  daoa_in_if  in_ch();
  daoa_out_if out_ch();

  dac_amplitude_offset_aligner u_dut (
    .clk       (clk),
    .rst       (rst),
    .din       (in_ch),
    .dout      (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  aligner_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .updates    (updates)
  );

  always #6 clk = ~clk;

  task automatic push_item(kind_t k, int val, bit frc, bit allow_gap);
    @(negedge clk);
    if (allow_gap && gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= k;
    in_ch.write_value  <= VOLT_W'(val);
    in_ch.force_update <= frc;
    last_val[k] = val;
    items_sent++;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Mostly values near the legal window, some repeats to hit unchanged writes, some noise.
  task automatic send_random(bit allow_gap);
    kind_t k;
    int    val, span;
    k    = kind_t'($urandom_range(0, 3));
    span = int'(setup.output_max) + 10;
    case ($urandom_range(0, 9))
      0, 1:    val = int'($urandom_range(0, 16383)) - 8192;
      2, 3:    val = last_val[k];
      default: begin
        if (k == KIND_VPP) val = int'($urandom_range(0, 2 * span));
        else val = int'($urandom_range(0, 2 * span)) - span;
      end
    endcase
    push_item(k, val, $urandom_range(0, 3) == 0, allow_gap);
  endtask

  // Drop valid and hold until every outstanding item has come back.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
  endtask

  task automatic apply_setup(cfg_t c);
    settle();
    put_reg(REG_OUTPUT_MAX, CFG_DATA_W'(c.output_max));
    put_reg(REG_MIN_VPP, CFG_DATA_W'(c.min_vpp));
    put_reg(REG_VPP_GAIN, CFG_DATA_W'(c.vpp_gain));
    put_reg(REG_VO_GAIN, CFG_DATA_W'(c.vo_gain));
    put_reg(REG_FULL_SCALE, CFG_DATA_W'(c.dac_full_scale));
    put_reg(REG_CHANNEL, CFG_DATA_W'(c.channel));
    @(negedge clk);
    cfg_write <= 1'b0;
    setup = c;
    setups_done++;
  endtask

  function automatic cfg_t pick_setup(int p);
    cfg_t c;
    case (p)
      0: c = DEFAULT_SETUP;
      1: c = '0;
      2: c = '1;
      3: begin
        c.output_max     = OMAX_W'($urandom());
        c.min_vpp        = MINVPP_W'($urandom());
        c.vpp_gain       = GAIN_W'($urandom());
        c.vo_gain        = GAIN_W'($urandom());
        c.dac_full_scale = FS_W'($urandom());
        c.channel        = CHAN_W'($urandom());
      end
      default: begin
        c.output_max     = OMAX_W'($urandom_range(100, 1000));
        c.min_vpp        = MINVPP_W'($urandom_range(0, 60));
        c.vpp_gain       = GAIN_W'($urandom_range(30000, 140000));
        c.vo_gain        = GAIN_W'($urandom_range(30000, 140000));
        c.dac_full_scale = FS_W'($urandom_range(255, 4095));
        c.channel        = CHAN_W'($urandom());
      end
    endcase
    return c;
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int served, hold_left, stall_left;
    served       = 0;
    hold_left    = 0;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (served != hold_asked) begin
        served    = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles", cycles);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_VPP;
    in_ch.write_value  = '0;
    in_ch.force_update = 1'b0;
    cfg_write          = 1'b0;
    cfg_index          = REG_OUTPUT_MAX;
    cfg_data           = '0;
    gaps_on            = 1'b1;
    items_sent         = 0;
    setups_done        = 0;
    hold_asked         = 0;
    last_val           = '{default: 0};
    setup              = DEFAULT_SETUP;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    apply_setup(DEFAULT_SETUP);
    // Unchanged writes first, while the held values are still the reset ones.
    push_item(KIND_VPP, 500, 1'b0, 1'b1);
    push_item(KIND_VPP, 500, 1'b1, 1'b1);
    push_item(KIND_OFFSET, 0, 1'b0, 1'b1);
    push_item(KIND_VMIN, -250, 1'b0, 1'b1);
    push_item(KIND_VMAX, 250, 1'b1, 1'b1);
    push_item(KIND_VPP, -8192, 1'b0, 1'b1);
    push_item(KIND_VPP, 8191, 1'b0, 1'b1);
    push_item(KIND_OFFSET, 8191, 1'b0, 1'b1);
    push_item(KIND_OFFSET, -8192, 1'b0, 1'b1);
    push_item(KIND_OFFSET, 0, 1'b1, 1'b1);
    push_item(KIND_VPP, 300, 1'b0, 1'b1);
    push_item(KIND_OFFSET, 450, 1'b0, 1'b1);
    push_item(KIND_OFFSET, -120, 1'b0, 1'b1);
    push_item(KIND_VPP, 1000, 1'b0, 1'b1);
    push_item(KIND_VMIN, -8192, 1'b0, 1'b1);
    push_item(KIND_VMIN, 8191, 1'b1, 1'b1);
    push_item(KIND_VMAX, 8191, 1'b0, 1'b1);
    push_item(KIND_VMAX, -8192, 1'b0, 1'b1);
    push_item(KIND_VMIN, -1, 1'b0, 1'b1);
    push_item(KIND_VMAX, -1, 1'b0, 1'b1);
    push_item(KIND_VPP, 0, 1'b0, 1'b1);

    for (int p = 0; p < SETUP_COUNT; p++) begin
      apply_setup(pick_setup(p));
      if (p == SETUP_COUNT - 1) gaps_on = 1'b0;
      for (int n = 0; n < ITEMS_PER_SETUP; n++) begin
        if (p == 2 && n == 60) begin
          // Stall the result side and keep offering items so the input backs up.
          hold_asked++;
          repeat (30) send_random(1'b0);
        end
        if (p == 3 && n == 140) settle();
        send_random(1'b1);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Summary: %0d items under %0d register settings, %0d results compared,",
             items_sent, setups_done, checked);
    $display("%0d with hw_update; clamps on every kind, unchanged and forced writes, long stall",
             updates);
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

FILE: sim.f
rtl/daoa_pkg.sv
rtl/daoa_in_if.sv
rtl/daoa_out_if.sv
rtl/daoa_cfg_regs.sv
rtl/daoa_align.sv
rtl/daoa_dac_word.sv
rtl/dac_amplitude_offset_aligner.sv
verif/aligner_checker.sv
verif/tb.sv
